// ----- rtl/alf_pkg.sv -----
// Shared types and constants of the accelerometer log line framer.
`default_nettype none

package alf_pkg;

	// Bits of each axis sample that the encoder uses.
	localparam int SAMPLE_BITS = 12;
	localparam int IN_W        = 12;
	localparam int EXT_W       = 16;
	localparam int VAL_W       = SAMPLE_BITS;
	localparam int QUO_W       = 8;
	localparam int REM_W       = 7;
	localparam int AXES        = 3;

	// v / 100 as (v * 5243) >> 19, exact for values below 2**14.
	localparam int DIV_MUL   = 5243;
	localparam int DIV_MUL_W = 13;
	localparam int DIV_SHIFT = 19;
	localparam int PROD_W    = VAL_W + DIV_MUL_W;

	localparam logic [7:0] DIGIT_BIAS  = 8'd28;
	localparam logic [7:0] NEWLINE     = 8'd10;
	localparam logic [7:0] HEADER_BYTE = 8'd126;
	localparam logic [7:0] MARKER_BYTE = 8'd127;

	localparam logic [7:0] SYNC_RESET = 8'd4;

	localparam int LINE_LEN = 7;
	localparam int IDX_W    = 3;

	localparam int CMD_DEPTH = 2;
	localparam int PTR_W     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

	// Request codes on req_type.
	localparam logic [1:0] REQ_START  = 2'd0;
	localparam logic [1:0] REQ_SAMPLE = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	// Command kinds passed from the front to the back.
	localparam logic [1:0] CMD_HEADER = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_MARKER = 2'd2;
	localparam logic [1:0] CMD_STOP   = 2'd3;

	typedef struct packed {
		logic [1:0]                  kind;
		logic                        flush;
		logic [AXES-1:0][VAL_W-1:0]  val;
		logic [AXES-1:0][QUO_W-1:0]  quo;
	} alf_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/alf_cmd_fifo.sv -----
// Short command queue between the classifying front and the byte emitting back.
`default_nettype none

module alf_cmd_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire alf_pkg::alf_cmd_t wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output alf_pkg::alf_cmd_t    rd_data,
	output logic                 empty
);
	import alf_pkg::*;

	alf_cmd_t            entry_q [CMD_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = (count_q == CNT_W'(CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/alf_front.sv -----
// Front end: takes requests, keeps the recording state and queues line commands.
`default_nettype none

module alf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [1:0]        req_type,
	input  wire logic [11:0]       x_value,
	input  wire logic [11:0]       y_value,
	input  wire logic [11:0]       z_value,
	input  wire logic              card_present,
	input  wire logic              cfg_we,
	input  wire logic [7:0]        cfg_data,
	output logic                   cmd_push,
	output alf_pkg::alf_cmd_t      cmd
);
	import alf_pkg::*;

	logic        recording_q;
	logic        seen_q;
	logic [7:0]  countdown_q;
	logic [7:0]  interval_q;
	logic [7:0]  count_dec;
	logic        fault;

	logic [AXES-1:0][IN_W-1:0]   raw;
	logic [AXES-1:0][EXT_W-1:0]  ext;
	logic [AXES-1:0][VAL_W-1:0]  val;
	logic [AXES-1:0][PROD_W-1:0] prod;
	logic [AXES-1:0][QUO_W-1:0]  quo;

	assign raw[0] = x_value;
	assign raw[1] = y_value;
	assign raw[2] = z_value;

	// Each axis is masked to the sample width and divided by 100 by a reciprocal multiply.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			ext[a]  = EXT_W'(raw[a]);
			val[a]  = ext[a][VAL_W-1:0];
			prod[a] = PROD_W'(val[a]) * PROD_W'(DIV_MUL);
			quo[a]  = QUO_W'(prod[a] >> DIV_SHIFT);
		end
	end

	assign fault     = !seen_q || !card_present;
	assign count_dec = (countdown_q != 8'd0) ? countdown_q - 8'd1 : 8'd0;

	always_comb begin
		cmd_push  = 1'b0;
		cmd.kind  = CMD_HEADER;
		cmd.flush = 1'b0;
		cmd.val   = val;
		cmd.quo   = quo;
		unique case (req_type)
			REQ_START: begin
				cmd_push = accept && !recording_q && card_present;
				cmd.kind = CMD_HEADER;
			end
			REQ_SAMPLE: begin
				cmd_push = accept && recording_q;
				cmd.kind = CMD_SAMPLE;
			end
			REQ_TICK: begin
				cmd_push  = accept && recording_q;
				cmd.kind  = fault ? CMD_STOP : CMD_MARKER;
				cmd.flush = !fault && (count_dec == 8'd0);
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recording_q <= 1'b0;
			seen_q      <= 1'b0;
			countdown_q <= 8'd0;
			interval_q  <= SYNC_RESET;
		end else begin
			if (cfg_we) begin
				interval_q <= cfg_data;
			end
			if (cmd_push) begin
				unique case (cmd.kind)
					CMD_HEADER: begin
						countdown_q <= interval_q;
						recording_q <= 1'b1;
					end
					CMD_SAMPLE: begin
						seen_q <= 1'b1;
					end
					CMD_MARKER: begin
						seen_q      <= 1'b0;
						countdown_q <= cmd.flush ? interval_q : count_dec;
					end
					CMD_STOP: begin
						recording_q <= 1'b0;
					end
					default: begin
						recording_q <= recording_q;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/alf_back.sv -----
// Back end: walks the queued command byte by byte into the result register.
`default_nettype none

module alf_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire alf_pkg::alf_cmd_t cmd,
	input  wire logic              cmd_empty,
	output logic                   cmd_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic [7:0]             out_byte,
	output logic                   byte_valid,
	output logic                   last,
	output logic                   flush_point,
	output logic                   stopped
);
	import alf_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic              out_vld_q;
	logic [7:0]        byte_q;
	logic              bvalid_q;
	logic              last_q;
	logic              flush_q;
	logic              stop_q;

	logic              advance;
	logic [VAL_W-1:0]  sel_val;
	logic [QUO_W-1:0]  sel_quo;
	logic [VAL_W-1:0]  rem_full;
	logic [REM_W-1:0]  rem;
	logic [7:0]        nxt_byte;
	logic              nxt_bvalid;
	logic              nxt_last;
	logic              nxt_flush;
	logic              nxt_stop;
	logic              at_newline;

	assign empty       = !out_vld_q;
	assign out_byte    = byte_q;
	assign byte_valid  = bvalid_q;
	assign last        = last_q;
	assign flush_point = flush_q;
	assign stopped     = stop_q;

	assign advance    = !cmd_empty && (!out_vld_q || pop);
	assign at_newline = (idx_q == IDX_W'(LINE_LEN - 1));

	// Pairs of byte slots belong to one axis: quotient first, then remainder.
	always_comb begin
		case (idx_q[IDX_W-1:1])
			2'd0: begin
				sel_val = cmd.val[0];
				sel_quo = cmd.quo[0];
			end
			2'd1: begin
				sel_val = cmd.val[1];
				sel_quo = cmd.quo[1];
			end
			default: begin
				sel_val = cmd.val[2];
				sel_quo = cmd.quo[2];
			end
		endcase
		rem_full = sel_val - (VAL_W'(sel_quo) * VAL_W'(7'd100));
		rem      = rem_full[REM_W-1:0];
	end

	always_comb begin
		nxt_byte   = NEWLINE;
		nxt_bvalid = 1'b1;
		nxt_last   = at_newline;
		nxt_flush  = 1'b0;
		nxt_stop   = 1'b0;
		unique case (cmd.kind)
			CMD_HEADER: begin
				nxt_byte = at_newline ? NEWLINE : HEADER_BYTE;
			end
			CMD_MARKER: begin
				nxt_byte  = at_newline ? NEWLINE : MARKER_BYTE;
				nxt_flush = at_newline && cmd.flush;
			end
			CMD_SAMPLE: begin
				if (at_newline) begin
					nxt_byte = NEWLINE;
				end else if (idx_q[0]) begin
					nxt_byte = 8'(rem) + DIGIT_BIAS;
				end else begin
					nxt_byte = sel_quo + DIGIT_BIAS;
				end
			end
			CMD_STOP: begin
				nxt_byte   = 8'd0;
				nxt_bvalid = 1'b0;
				nxt_last   = 1'b1;
				nxt_stop   = 1'b1;
			end
			default: begin
				nxt_byte = NEWLINE;
			end
		endcase
	end

	assign cmd_pop = advance && nxt_last;

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q   <= nxt_byte;
			bvalid_q <= nxt_bvalid;
			last_q   <= nxt_last;
			flush_q  <= nxt_flush;
			stop_q   <= nxt_stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				out_vld_q <= 1'b1;
				idx_q     <= nxt_last ? '0 : idx_q + 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/accel_log_line_framer.sv -----
// Top level of the accelerometer log line framer.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------------------
//   request   | push / full               | req_type, x_value, y_value, z_value,
//             |                           | card_present
//   result    | pop / empty               | out_byte, byte_valid, last, flush_point,
//             |                           | stopped
//   config    | cfg_valid / cfg_ready     | cfg_data (sync_interval)
//
// A header, sample or marker item produces seven results, one per cycle while the
// result side keeps popping, through the single byte-wide result register. A stop
// item produces a single result. The front classifies an item in the cycle it is
// accepted and queues it in a two-entry command queue; the back then moves each result
// into the result register. Reset is asynchronous and clears all control state. A stalled
// result side fills the queue, then raises full; cfg_ready is always high.
`default_nettype none

module accel_log_line_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  req_type,
	input  wire logic [11:0] x_value,
	input  wire logic [11:0] y_value,
	input  wire logic [11:0] z_value,
	input  wire logic        card_present,
	input  wire logic        pop,
	output logic             empty,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             last,
	output logic             flush_point,
	output logic             stopped,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);
	import alf_pkg::*;

	alf_cmd_t  push_cmd;
	alf_cmd_t  head_cmd;
	logic      cmd_push;
	logic      cmd_pop;
	logic      cmd_full;
	logic      cmd_empty;
	logic      accept;

	assign cfg_ready = 1'b1;
	assign full      = cmd_full;
	assign accept    = push && !cmd_full;

	alf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.x_value      (x_value),
		.y_value      (y_value),
		.z_value      (z_value),
		.card_present (card_present),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.cmd_push     (cmd_push),
		.cmd          (push_cmd)
	);

	alf_cmd_fifo u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (push_cmd),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (head_cmd),
		.empty   (cmd_empty)
	);

	alf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (head_cmd),
		.cmd_empty   (cmd_empty),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last        (last),
		.flush_point (flush_point),
		.stopped     (stopped)
	);

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench of the accelerometer log line framer, checked against a predictor.
module tb;
	import alf_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES   = 20;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 71;
	localparam int PHASES          = 5;

	typedef struct packed {
		logic [7:0] ch;
		logic       valid;
		logic       last;
		logic       flush;
		logic       stop;
	} log_byte_t;

	// One request item, with an optional hand-typed view of the line it causes.
	typedef struct packed {
		logic [1:0]  req;
		logic [11:0] x;
		logic [11:0] y;
		logic [11:0] z;
		logic        card;
		logic        typed;
		logic [2:0]  n;
		logic [7:0]  ch0;
		logic        flush;
		logic        stop;
	} stim_row_t;

	typedef enum int {POP_ALWAYS, POP_COIN, POP_PATTERN, POP_SPARSE} pop_mode_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        push         = 1'b0;
	logic        full;
	logic [1:0]  req_type     = REQ_START;
	logic [11:0] x_value      = '0;
	logic [11:0] y_value      = '0;
	logic [11:0] z_value      = '0;
	logic        card_present = 1'b0;
	logic        pop          = 1'b0;
	logic        empty;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last;
	logic        flush_point;
	logic        stopped;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data     = '0;

	// Predictor state.
	bit         rec_on       = 1'b0;
	bit         seen_sample  = 1'b0;
	logic [7:0] sec_left     = '0;
	logic [7:0] flush_period = SYNC_RESET;

	log_byte_t pending_bytes[$];
	log_byte_t head_byte;
	int        mismatch_count = 0;
	int        burst_left     = 0;
	int        cycle_count    = 0;
	pop_mode_t pop_mode       = POP_ALWAYS;
	int        mode_left      = 0;
	logic [7:0] pop_pattern   = '0;

	stim_row_t directed_rows [25] = '{
		'{REQ_SAMPLE, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_START, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_UNUSED, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_START, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd7, HEADER_BYTE, 1'b0, 1'b0},
		'{REQ_START, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd1, 8'd0, 1'b0, 1'b1},
		'{REQ_START, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd7, HEADER_BYTE, 1'b0, 1'b0},
		'{REQ_SAMPLE, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd7, DIGIT_BIAS, 1'b0, 1'b0},
		'{REQ_SAMPLE, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 1'b1, 3'd7, 8'd68, 1'b0, 1'b0},
		'{REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd7, MARKER_BYTE, 1'b0, 1'b0},
		'{REQ_SAMPLE, 12'd99, 12'd100, 12'd1234, 1'b0, 1'b0, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_SAMPLE, 12'hAAA, 12'h555, 12'hF0F, 1'b1, 1'b0, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_TICK, 12'hAAA, 12'h555, 12'hF0F, 1'b1, 1'b0, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_SAMPLE, 12'h555, 12'hAAA, 12'h0F0, 1'b1, 1'b0, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd7, MARKER_BYTE, 1'b1, 1'b0},
		'{REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd1, 8'd0, 1'b0, 1'b1},
		'{REQ_SAMPLE, 12'd5, 12'd6, 12'd7, 1'b1, 1'b1, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_START, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd7, HEADER_BYTE, 1'b0, 1'b0},
		'{REQ_SAMPLE, 12'd1, 12'd2, 12'd3, 1'b1, 1'b0, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1, 3'd1, 8'd0, 1'b0, 1'b1},
		'{REQ_START, 12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 3'd7, HEADER_BYTE, 1'b0, 1'b0},
		'{REQ_TICK, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0, 3'd0, 8'd0, 1'b0, 1'b0},
		'{REQ_UNUSED, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0, 1'b1, 3'd0, 8'd0, 1'b0, 1'b0}
	};

	accel_log_line_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.x_value      (x_value),
		.y_value      (y_value),
		.z_value      (z_value),
		.card_present (card_present),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last         (last),
		.flush_point  (flush_point),
		.stopped      (stopped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic log_byte_t line_byte(logic [7:0] ch, logic valid, logic lst,
			logic fl, logic st);
		log_byte_t b;
		b.ch    = ch;
		b.valid = valid;
		b.last  = lst;
		b.flush = fl;
		b.stop  = st;
		return b;
	endfunction

	// Updates the framer state for one accepted item and returns the bytes it emits.
	function automatic int frame_request(logic [1:0] req, logic [11:0] xv, logic [11:0] yv,
			logic [11:0] zv, logic card, output log_byte_t line [7]);
		logic [11:0] axis [3];
		int          v;
		logic [7:0]  fill;
		logic        fl;
		fill = HEADER_BYTE;
		fl   = 1'b0;
		axis = '{xv, yv, zv};
		case (req)
			REQ_START: begin
				if (rec_on || !card)
					return 0;
				sec_left = flush_period;
				rec_on   = 1'b1;
			end
			REQ_SAMPLE: begin
				if (!rec_on)
					return 0;
				for (int a = 0; a < 3; a++) begin
					v = int'(axis[a]) & ((1 << SAMPLE_BITS) - 1);
					line[2*a]   = line_byte(8'(v / 100) + DIGIT_BIAS, 1'b1, 1'b0, 1'b0, 1'b0);
					line[2*a+1] = line_byte(8'(v % 100) + DIGIT_BIAS, 1'b1, 1'b0, 1'b0, 1'b0);
				end
				line[6]     = line_byte(NEWLINE, 1'b1, 1'b1, 1'b0, 1'b0);
				seen_sample = 1'b1;
				return 7;
			end
			REQ_TICK: begin
				if (!rec_on)
					return 0;
				if (!seen_sample || !card) begin
					rec_on  = 1'b0;
					line[0] = line_byte(8'd0, 1'b0, 1'b1, 1'b0, 1'b1);
					return 1;
				end
				seen_sample = 1'b0;
				if (sec_left != 0)
					sec_left = sec_left - 8'd1;
				// With a zero interval the countdown reloads to zero, so every marker flushes.
				if (sec_left == 0) begin
					sec_left = flush_period;
					fl       = 1'b1;
				end
				fill = MARKER_BYTE;
			end
			default: return 0;
		endcase
		for (int k = 0; k < 6; k++)
			line[k] = line_byte(fill, 1'b1, 1'b0, 1'b0, 1'b0);
		line[6] = line_byte(NEWLINE, 1'b1, 1'b1, fl, 1'b0);
		return 7;
	endfunction

	function automatic logic [11:0] axis_value();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: return 12'd0;
				1: return 12'hFFF;
				2: return 12'd99;
				default: return 12'd100;
			endcase
		end
		return 12'($urandom_range(0, 4095));
	endfunction

	// Mostly well-formed recording sessions; a few stray requests while idle or busy.
	function automatic stim_row_t random_request();
		stim_row_t row;
		int        pick;
		row      = '0;
		row.x    = axis_value();
		row.y    = axis_value();
		row.z    = axis_value();
		row.card = 1'($urandom_range(0, 1));
		if (!rec_on) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				row.req  = REQ_START;
				row.card = ($urandom_range(0, 9) != 0);
			end else if (pick == 8) begin
				row.req = ($urandom_range(0, 1) != 0) ? REQ_SAMPLE : REQ_TICK;
			end else begin
				row.req = REQ_UNUSED;
			end
		end else begin
			pick = $urandom_range(0, 19);
			if (pick < 12) begin
				row.req = REQ_SAMPLE;
			end else if (pick < 18) begin
				row.req  = REQ_TICK;
				row.card = ($urandom_range(0, 15) != 0);
			end else if (pick == 18) begin
				row.req = REQ_START;
			end else begin
				row.req = REQ_UNUSED;
			end
		end
		return row;
	endfunction

	task automatic note_mismatch(string field, int exp_v, int act_v);
		$error("%s: expected %0d, got %0d", field, exp_v, act_v);
		mismatch_count++;
	endtask

	task automatic send_request(input stim_row_t row, output int n);
		log_byte_t line [7];
		int        gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		push         <= 1'b1;
		req_type     <= row.req;
		x_value      <= row.x;
		y_value      <= row.y;
		z_value      <= row.z;
		card_present <= row.card;
		do
			@(posedge clk);
		while (full);
		n = frame_request(row.req, row.x, row.y, row.z, row.card, line);
		if (row.typed) begin
			if (n != int'(row.n)) begin
				note_mismatch("line length", row.n, n);
			end else if (n > 0) begin
				if (line[0].ch != row.ch0)
					note_mismatch("first out_byte", row.ch0, line[0].ch);
				if (line[n-1].flush != row.flush)
					note_mismatch("final flush_point", row.flush, line[n-1].flush);
				if (line[n-1].stop != row.stop)
					note_mismatch("final stopped", row.stop, line[n-1].stop);
			end
		end
		for (int k = 0; k < n; k++)
			pending_bytes.push_back(line[k]);
	endtask

	// Holds the sender off until every expected byte has been taken.
	task automatic wait_drained();
		push       <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync_interval(input logic [7:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		flush_period = value;
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_bytes.size() == 0) begin
				$error("result with no item waiting for it: out_byte %0d", out_byte);
				mismatch_count++;
			end else begin
				head_byte = pending_bytes.pop_front();
				if (out_byte != head_byte.ch)
					note_mismatch("out_byte", head_byte.ch, out_byte);
				if (byte_valid != head_byte.valid)
					note_mismatch("byte_valid", head_byte.valid, byte_valid);
				if (last != head_byte.last)
					note_mismatch("last", head_byte.last, last);
				if (flush_point != head_byte.flush)
					note_mismatch("flush_point", head_byte.flush, flush_point);
				if (stopped != head_byte.stop)
					note_mismatch("stopped", head_byte.stop, stopped);
			end
		end
		if (mode_left == 0) begin
			pop_mode    = pop_mode_t'($urandom_range(0, 3));
			mode_left   = $urandom_range(16, 96);
			pop_pattern = 8'($urandom);
		end
		mode_left--;
		case (pop_mode)
			POP_ALWAYS: pop <= 1'b1;
			POP_COIN:   pop <= 1'($urandom_range(0, 1));
			POP_PATTERN: begin
				pop <= pop_pattern[0];
				pop_pattern = {pop_pattern[0], pop_pattern[7:1]};
			end
			default: pop <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [7:0] intervals [PHASES];
		int         produced;
		int         n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[k])
			send_request(directed_rows[k], n);
		// Shortest, longest and zero interval, then a few ordinary ones.
		intervals = '{8'd1, 8'd255, 8'd0, 8'd3, 8'($urandom_range(1, 255))};
		for (int p = 0; p < PHASES; p++) begin
			write_sync_interval(intervals[p]);
			produced = 0;
			while (produced < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 59) == 0)
					wait_drained();
				send_request(random_request(), n);
				produced++;
			end
		end
		wait_drained();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
